// ===== rtl/itoa_pkg.sv =====
// Shared types and constants for the integer to ASCII formatter.
package itoa_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int DEC_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int HEX_DIGITS  = (VALUE_WIDTH + 3) / 4;
    localparam int DIG_BITS    = DEC_DIGITS * 4;
    localparam int HEX_BITS    = HEX_DIGITS * 4;
    localparam int PAD_BITS    = DIG_BITS - HEX_BITS;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int LEFT_W      = $clog2(DEC_DIGITS + 1);

    localparam logic [6:0] CH_ZERO = 7'h30;
    localparam logic [6:0] CH_A    = 7'h41;
    localparam logic [6:0] CH_X    = 7'h78;

    localparam logic CMD_DEC = 1'b0;
    localparam logic CMD_HEX = 1'b1;

    typedef struct packed {
        logic        command;
        logic [63:0] value;
    } t_in;

    typedef struct packed {
        logic [6:0] character;
        logic       last;
    } t_out;

endpackage

// ===== rtl/itoa_dabble.sv =====
// Iterative shift-and-add-3 unit that turns a binary value into BCD digits.
module itoa_dabble (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [itoa_pkg::VALUE_WIDTH-1:0]    i_value,
    output logic                                o_done,
    output logic [itoa_pkg::DIG_BITS-1:0]       o_bcd
);

    logic [itoa_pkg::VALUE_WIDTH-1:0] r_bin;
    logic [itoa_pkg::VALUE_WIDTH-1:0] n_bin;
    logic [itoa_pkg::DIG_BITS-1:0]    r_bcd;
    logic [itoa_pkg::DIG_BITS-1:0]    n_bcd;
    logic [itoa_pkg::DIG_BITS-1:0]    adj;
    logic [itoa_pkg::CNT_W-1:0]       r_cnt;
    logic                             r_busy;
    logic                             r_done;

    always_comb begin
        for (int d = 0; d < itoa_pkg::DEC_DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
        {n_bcd, n_bin} = {adj, r_bin} << 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_bin  <= i_value;
                r_bcd  <= '0;
                r_cnt  <= itoa_pkg::CNT_W'(itoa_pkg::VALUE_WIDTH);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_bin <= n_bin;
                r_bcd <= n_bcd;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == itoa_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a conversion in progress");
    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("start while a conversion is in progress");
    a_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("busy with an exhausted bit count");
`endif

endmodule

// ===== rtl/integer_to_ascii_formatter_top.sv =====
// Top level of the integer to ASCII formatter: sequencer, digit buffer and output register.
//
//  channel  direction  handshake               payload
//  in       receive    i_in_valid, o_in_stall  i_in_data  (command, value)
//  out      send       o_out_valid, i_out_stall o_out_data (character, last)
//
// A decimal value is converted in the shift-and-add-3 unit, one bit per cycle.
// Leading zero digits are then dropped at one digit per cycle, and each character
// waits for a free output register.
// A hex item skips the conversion and is sent behind a 0x prefix.
// Reset is synchronous and clears the sequencer and the output valid register.
// The input is stalled for the whole item; a stalled output beat holds the prefix and emit states.
module integer_to_ascii_formatter_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  itoa_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output itoa_pkg::t_out o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_PFX0,
        S_PFXX,
        S_SKIP,
        S_EMIT
    } t_state;

    t_state                            r_state;
    t_state                            n_state;
    logic [itoa_pkg::DIG_BITS-1:0]     r_dig;
    logic [itoa_pkg::DIG_BITS-1:0]     n_dig;
    logic [itoa_pkg::LEFT_W-1:0]       r_left;
    logic [itoa_pkg::LEFT_W-1:0]       n_left;
    logic                              r_out_valid;
    logic                              n_out_valid;
    itoa_pkg::t_out                    r_out;
    itoa_pkg::t_out                    n_out;

    logic                              in_take;
    logic                              out_free;
    logic                              dab_done;
    logic [itoa_pkg::DIG_BITS-1:0]     dab_bcd;
    logic [itoa_pkg::HEX_BITS-1:0]     hex_ext;
    logic [3:0]                        top_nib;
    logic [6:0]                        top_char;

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign top_nib  = r_dig[itoa_pkg::DIG_BITS-1 -: 4];

    itoa_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_take && (i_in_data.command == itoa_pkg::CMD_DEC)),
        .i_value (i_in_data.value[itoa_pkg::VALUE_WIDTH-1:0]),
        .o_done  (dab_done),
        .o_bcd   (dab_bcd)
    );

    always_comb begin
        hex_ext = '0;
        hex_ext[itoa_pkg::VALUE_WIDTH-1:0] = i_in_data.value[itoa_pkg::VALUE_WIDTH-1:0];
        if (top_nib <= 4'd9) begin
            top_char = itoa_pkg::CH_ZERO + {3'b000, top_nib};
        end else begin
            top_char = itoa_pkg::CH_A + {3'b000, top_nib} - 7'd10;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_dig       = r_dig;
        n_left      = r_left;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.command == itoa_pkg::CMD_HEX) begin
                        n_dig   = itoa_pkg::DIG_BITS'(hex_ext) << itoa_pkg::PAD_BITS;
                        n_left  = itoa_pkg::LEFT_W'(itoa_pkg::HEX_DIGITS);
                        n_state = S_PFX0;
                    end else begin
                        n_state = S_CONV;
                    end
                end
            end
            S_CONV: begin
                if (dab_done) begin
                    n_dig   = dab_bcd;
                    n_left  = itoa_pkg::LEFT_W'(itoa_pkg::DEC_DIGITS);
                    n_state = S_SKIP;
                end
            end
            S_PFX0: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.character = itoa_pkg::CH_ZERO;
                    n_out.last      = 1'b0;
                    n_state         = S_PFXX;
                end
            end
            S_PFXX: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.character = itoa_pkg::CH_X;
                    n_out.last      = 1'b0;
                    n_state         = S_SKIP;
                end
            end
            S_SKIP: begin
                if (top_nib == 4'd0 && r_left != itoa_pkg::LEFT_W'(1)) begin
                    n_dig  = r_dig << 4;
                    n_left = r_left - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.character = top_char;
                    n_out.last      = (r_left == itoa_pkg::LEFT_W'(1));
                    n_dig           = r_dig << 4;
                    n_left          = r_left - 1'b1;
                    if (r_left == itoa_pkg::LEFT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
        r_dig <= n_dig;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state != S_IDLE))
        else $error("accepted beat did not start an item");
    a_left_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SKIP || r_state == S_EMIT) |-> (r_left != '0))
        else $error("digit walk with no digits left");
    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dab_done |-> (r_state == S_CONV))
        else $error("conversion finished outside the conversion state");
`endif

endmodule
